// ===== src/pal_pkg.sv =====
`default_nettype none

package pal_pkg;

  localparam int unsigned REQ_W  = 3;
  localparam int unsigned POS_W  = 7;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned IDX_W  = 6;
  localparam int unsigned CNT_W  = 7;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT   = 3'd0,
    REQ_DELETE   = 3'd1,
    REQ_SEARCH   = 3'd2,
    REQ_UPDATE   = 3'd3,
    REQ_TRAVERSE = 3'd4
  } req_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

endpackage

`default_nettype wire

// ===== src/pal_ram.sv =====
`default_nettype none

module pal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== src/positional_array_list.sv =====
// Channel | Handshake                 | Payload
// in      | in_valid_i / in_ready_o   | req_type_i, position_i, value_i
// out     | out_valid_o / out_ready_i | status_o, data_o, found_index_o, entry_count_o, last_o
//
// One request at a time; the store is a RAM with one read and one write port,
// and every walk over it moves one entry per cycle (a traverse only while the
// output is not stalled). Insert moves the entries from the position on up one
// place, then writes; delete moves the later ones down; search stops at a hit.
// Reset clears the entry count and the FSM; the store needs no clearing pass.
// A stalled output holds the walk (traverse) or the final result in place.
`default_nettype none

module positional_array_list
  import pal_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic [REQ_W-1:0]         req_type_i,
  input  wire logic [POS_W-1:0]         position_i,
  input  wire logic signed [DATA_W-1:0] value_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic [ST_W-1:0]               status_o,
  output logic signed [DATA_W-1:0]      data_o,
  output logic [IDX_W-1:0]              found_index_o,
  output logic [CNT_W-1:0]              entry_count_o,
  output logic                          last_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_TAIL,
    S_WRVAL,
    S_TRAV_OUT,
    S_RESP
  } state_e;

  state_e            state_q;
  req_e              req_q;
  logic [POS_W-1:0]  pos_q;
  logic [DATA_W-1:0] val_q;
  logic [CW-1:0]     count_q;
  logic [AW-1:0]     ptr_q;
  logic [AW-1:0]     end_q;
  logic [AW-1:0]     last_addr_q;
  logic              rv_q;
  logic [AW-1:0]     rva_q;
  status_e           pend_status_q;
  logic [DATA_W-1:0] pend_data_q;
  logic [AW-1:0]     pend_idx_q;

  logic              out_valid_q;
  status_e           status_q;
  logic [DATA_W-1:0] data_q;
  logic [IDX_W-1:0]  found_q;
  logic [CNT_W-1:0]  count_out_q;
  logic              last_q;

  logic              re_c;
  logic [AW-1:0]     raddr_c;
  logic              we_c;
  logic [AW-1:0]     waddr_c;
  logic [DATA_W-1:0] wdata_c;
  logic [DATA_W-1:0] rdata;

  logic              out_free;
  logic              proc;
  logic              match;
  logic [AW-1:0]     pos_a;
  logic [POS_W-1:0]  count_p;

  assign pos_a    = pos_q[AW-1:0];
  assign count_p  = POS_W'(count_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign proc     = rv_q && (state_q inside {S_SCAN, S_TAIL});
  assign match    = (rdata == val_q);

  pal_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we_c),
    .waddr_i (waddr_c),
    .wdata_i (wdata_c),
    .re_i    (re_c),
    .raddr_i (raddr_c),
    .rdata_o (rdata)
  );

  always_comb begin
    re_c    = 1'b0;
    raddr_c = ptr_q;
    we_c    = 1'b0;
    waddr_c = rva_q;
    wdata_c = rdata;
    case (state_q)
      S_DECODE: begin
        if (req_q == REQ_TRAVERSE && count_q != '0) begin
          re_c    = 1'b1;
          raddr_c = '0;
        end
      end
      S_SCAN: begin
        re_c = 1'b1;
      end
      S_WRVAL: begin
        we_c    = 1'b1;
        waddr_c = pos_a;
        wdata_c = val_q;
      end
      S_TRAV_OUT: begin
        if (out_free && ptr_q != last_addr_q) begin
          re_c    = 1'b1;
          raddr_c = AW'(ptr_q + 1'b1);
        end
      end
      default: begin
      end
    endcase
    // move the entry just read one place up (insert) or down (delete)
    if (proc) begin
      if (req_q == REQ_INSERT) begin
        we_c    = 1'b1;
        waddr_c = AW'(rva_q + 1'b1);
      end else if (req_q == REQ_DELETE && rva_q != pos_a) begin
        we_c    = 1'b1;
        waddr_c = AW'(rva_q - 1'b1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      req_q         <= REQ_INSERT;
      pos_q         <= '0;
      val_q         <= '0;
      count_q       <= '0;
      ptr_q         <= '0;
      end_q         <= '0;
      last_addr_q   <= '0;
      rv_q          <= 1'b0;
      rva_q         <= '0;
      pend_status_q <= ST_OK;
      pend_data_q   <= '0;
      pend_idx_q    <= '0;
      out_valid_q   <= 1'b0;
      status_q      <= ST_OK;
      data_q        <= '0;
      found_q       <= '0;
      count_out_q   <= '0;
      last_q        <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      rv_q  <= (state_q == S_SCAN);
      rva_q <= ptr_q;

      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q   <= req_e'(req_type_i);
            pos_q   <= position_i;
            val_q   <= $unsigned(value_i);
            state_q <= S_DECODE;
          end
        end

        S_DECODE: begin
          pend_status_q <= ST_OK;
          pend_data_q   <= '0;
          pend_idx_q    <= '0;
          last_addr_q   <= AW'(count_q - 1'b1);
          case (req_q)
            REQ_INSERT: begin
              if (pos_q > count_p) begin
                pend_status_q <= ST_RANGE;
                state_q       <= S_RESP;
              end else if (count_q == CW'(CAPACITY)) begin
                pend_status_q <= ST_FULL;
                state_q       <= S_RESP;
              end else if (pos_q == count_p) begin
                state_q <= S_WRVAL;
              end else begin
                ptr_q   <= AW'(count_q - 1'b1);
                end_q   <= pos_a;
                state_q <= S_SCAN;
              end
            end
            REQ_DELETE, REQ_UPDATE: begin
              if (pos_q >= count_p) begin
                pend_status_q <= ST_RANGE;
                state_q       <= S_RESP;
              end else begin
                ptr_q   <= pos_a;
                end_q   <= (req_q == REQ_DELETE) ? AW'(count_q - 1'b1) : pos_a;
                state_q <= S_SCAN;
              end
            end
            REQ_SEARCH: begin
              if (count_q == '0) begin
                pend_status_q <= ST_MISS;
                state_q       <= S_RESP;
              end else begin
                ptr_q   <= '0;
                end_q   <= AW'(count_q - 1'b1);
                state_q <= S_SCAN;
              end
            end
            REQ_TRAVERSE: begin
              ptr_q   <= '0;
              state_q <= (count_q == '0) ? S_RESP : S_TRAV_OUT;
            end
            default: begin
              state_q <= S_RESP;
            end
          endcase
        end

        S_SCAN, S_TAIL: begin
          if (state_q == S_SCAN) begin
            if (ptr_q == end_q) begin
              state_q <= S_TAIL;
            end else if (req_q == REQ_INSERT) begin
              ptr_q <= AW'(ptr_q - 1'b1);
            end else begin
              ptr_q <= AW'(ptr_q + 1'b1);
            end
          end else begin
            case (req_q)
              REQ_INSERT, REQ_UPDATE: state_q <= S_WRVAL;
              REQ_DELETE: begin
                count_q <= CW'(count_q - 1'b1);
                state_q <= S_RESP;
              end
              default: begin
                // search: no hit in the last entry means a miss
                if (!match) begin
                  pend_status_q <= ST_MISS;
                end
                state_q <= S_RESP;
              end
            endcase
          end
          if (proc) begin
            if ((req_q inside {REQ_DELETE, REQ_UPDATE}) && rva_q == pos_a) begin
              pend_data_q <= rdata;
            end
            if (req_q == REQ_SEARCH && match) begin
              pend_idx_q <= rva_q;
              state_q    <= S_RESP;
            end
          end
        end

        S_WRVAL: begin
          if (req_q == REQ_INSERT) begin
            count_q <= CW'(count_q + 1'b1);
          end
          state_q <= S_RESP;
        end

        S_TRAV_OUT: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= ST_OK;
            data_q      <= rdata;
            found_q     <= '0;
            count_out_q <= CNT_W'(count_q);
            last_q      <= (ptr_q == last_addr_q);
            if (ptr_q == last_addr_q) begin
              state_q <= S_IDLE;
            end else begin
              ptr_q <= AW'(ptr_q + 1'b1);
            end
          end
        end

        S_RESP: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= pend_status_q;
            data_q      <= pend_data_q;
            found_q     <= IDX_W'(pend_idx_q);
            count_out_q <= CNT_W'(count_q);
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign data_o        = $signed(data_q);
  assign found_index_o = found_q;
  assign entry_count_o = count_out_q;
  assign last_o        = last_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we_c |-> (CW'(waddr_c) <= count_q))
    else $error("store write beyond the packed entries");

  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !we_c)
    else $error("store write while idle");

  a_partial_only_traverse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !last_q) |-> (state_q == S_TRAV_OUT))
    else $error("non-final result outside a traverse");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |->
      (count_q == CW'($past(count_q) + 1'b1) || count_q == CW'($past(count_q) - 1'b1)))
    else $error("entry count moved by more than one");
`endif

endmodule

`default_nettype wire
